### rtl/iaid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package iaid_pkg;

  // Field widths fixed by the request and result formats.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned ST_W   = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/iaid_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module iaid_cell #(
  parameter int unsigned CMPW = 8,
  parameter int unsigned IDX  = 0
) (
  input  wire                               clk,
  input  wire iaid_pkg::cell_cmd_t          cmd,
  input  wire logic [CMPW-1:0]              position,
  input  wire logic [iaid_pkg::WORD_W-1:0]  value_in,
  input  wire logic [iaid_pkg::WORD_W-1:0]  left,
  input  wire logic [iaid_pkg::WORD_W-1:0]  right,
  output logic      [iaid_pkg::WORD_W-1:0]  data,
  output logic      [iaid_pkg::WORD_W-1:0]  rd_data
);

  localparam logic [CMPW-1:0] MY_IDX = CMPW'(IDX);

  logic hit;
  logic above;

  // Compare this cell's place with the broadcast position.
  assign hit   = (position == MY_IDX);
  assign above = (MY_IDX > position);

  // An insert opens a gap at the position; a delete closes it.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (hit) begin
        data <= value_in;
      end else if (above) begin
        data <= left;
      end
    end else if (cmd.del) begin
      if (hit || above) begin
        data <= right;
      end
    end
  end

  // Only the addressed cell contributes to the read bus.
  assign rd_data = hit ? data : '0;

endmodule

`default_nettype wire

### rtl/indexed_array_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none

// Dense ordered array of signed 32-bit words with insert, delete and read at a
// position. Each word lives in one cell of a chain; an insert or delete moves
// every cell at or above the position by one place at once, driven by the
// position broadcast to all cells. One request is taken per cycle unless a
// held-back result stalls the input; its result is registered on acceptance
// and appears in the next cycle. Words are not cleared at reset, only the count
// and rsp_valid are, and no entry at or above the count is ever returned.
module indexed_array_insert_delete #(
  parameter int unsigned DEPTH = 128
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   req_valid,
  output logic                                  req_stall,
  input  wire logic [iaid_pkg::OP_W-1:0]        operation,
  input  wire logic [iaid_pkg::POS_W-1:0]       position,
  input  wire logic signed [iaid_pkg::WORD_W-1:0] value_in,
  output logic                                  rsp_valid,
  input  wire                                   rsp_stall,
  output logic      [iaid_pkg::ST_W-1:0]        status,
  output logic signed [iaid_pkg::WORD_W-1:0]    value_out,
  output logic      [$clog2(DEPTH+1)-1:0]       fill_count
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > iaid_pkg::POS_W) ? CW : iaid_pkg::POS_W;
  localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

  logic                            accept;
  logic [CW-1:0]                   count;
  logic [CW-1:0]                   count_next;
  logic [CMPW-1:0]                 pos_ext;
  logic [CMPW-1:0]                 count_ext;
  logic [iaid_pkg::ST_W-1:0]       status_next;
  logic [iaid_pkg::WORD_W-1:0]     value_next;
  logic [iaid_pkg::WORD_W-1:0]     rd_bus;
  iaid_pkg::cell_cmd_t             cmd;
  logic                            rsp_valid_next;

  logic [iaid_pkg::WORD_W-1:0]     cell_data [DEPTH];
  logic [iaid_pkg::WORD_W-1:0]     cell_rd   [DEPTH];

  // Handshake: a new request enters unless a result is held back.
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  assign pos_ext   = CMPW'(position);
  assign count_ext = CMPW'(count);

  // Read bus: at most one cell drives a nonzero word.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Decode the request into a status, a read word and a shift command.
  always_comb begin
    status_next = iaid_pkg::ST_OK;
    value_next  = '0;
    count_next  = count;
    cmd         = '0;
    case (operation)
      iaid_pkg::OP_INSERT: begin
        if (count_ext == DEPTH_C) begin
          status_next = iaid_pkg::ST_FULL;
        end else if (pos_ext > count_ext) begin
          status_next = iaid_pkg::ST_RANGE;
        end else begin
          cmd.ins    = accept;
          count_next = count + CW'(1);
        end
      end
      iaid_pkg::OP_DELETE: begin
        if (pos_ext >= count_ext) begin
          status_next = iaid_pkg::ST_RANGE;
        end else begin
          cmd.del    = accept;
          count_next = count - CW'(1);
        end
      end
      iaid_pkg::OP_READ: begin
        if (pos_ext >= count_ext) begin
          status_next = iaid_pkg::ST_RANGE;
        end else begin
          value_next = rd_bus;
        end
      end
      default: begin
        status_next = iaid_pkg::ST_OK;
      end
    endcase
  end

  // Chain of cells; the ends reuse their own word as the missing neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [iaid_pkg::WORD_W-1:0] left_w;
    logic [iaid_pkg::WORD_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end

    iaid_cell #(
      .CMPW (CMPW),
      .IDX  (g)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .position (pos_ext),
      .value_in (value_in),
      .left     (left_w),
      .right    (right_w),
      .data     (cell_data[g]),
      .rd_data  (cell_rd[g])
    );
  end

  // Result register valid flag.
  always_comb begin
    if (accept) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_stall) begin
      rsp_valid_next = rsp_valid;
    end else begin
      rsp_valid_next = 1'b0;
    end
  end

  // Count and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= rsp_valid_next;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      value_out  <= value_next;
      fill_count <= count_next;
    end
  end

  // The count never exceeds the array size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= DEPTH_C)
    else $error("fill count above capacity");

  // A successful insert grows the count by exactly one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.ins |=> count == $past(count) + CW'(1))
    else $error("insert did not raise count");

  // A full result is only reported at capacity.
  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == iaid_pkg::ST_FULL |-> CMPW'(fill_count) == DEPTH_C)
    else $error("full status below capacity");

  // A failed request never returns a word.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != iaid_pkg::ST_OK |-> value_out == '0)
    else $error("failed request returned data");

endmodule

`default_nettype wire

### verif/array_checker.sv
`timescale 1ns / 1ps

// Watches the request and response channels of the indexed array, keeps its
// own copy of the array contents and fill count, and compares every response
// with the outcome predicted for the oldest outstanding request.
module array_checker #(
  parameter int unsigned DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  input  logic                                  req_stall,
  input  logic [iaid_pkg::OP_W-1:0]             operation,
  input  logic [iaid_pkg::POS_W-1:0]            position,
  input  logic signed [iaid_pkg::WORD_W-1:0]    value_in,
  input  logic                                  rsp_valid,
  input  logic                                  rsp_stall,
  input  logic [iaid_pkg::ST_W-1:0]             status,
  input  logic signed [iaid_pkg::WORD_W-1:0]    value_out,
  input  logic [$clog2(DEPTH+1)-1:0]            fill_count,
  output int                                    mismatch_count,
  output int                                    pending_results
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef struct {
    logic [iaid_pkg::ST_W-1:0]          status;
    logic signed [iaid_pkg::WORD_W-1:0] word;
    logic [CNT_W-1:0]                   count;
  } outcome_t;

  // Shadow copy of the array and its fill count.
  logic signed [iaid_pkg::WORD_W-1:0] shadow_words [DEPTH];
  int unsigned                        shadow_count;

  outcome_t expected_results [$];
  outcome_t want;
  outcome_t got;

  // Applies one request to the shadow array and returns the response it should produce.
  function automatic outcome_t apply_request(logic [iaid_pkg::OP_W-1:0] op,
                                             int unsigned pos,
                                             logic signed [iaid_pkg::WORD_W-1:0] word);
    outcome_t res;
    res.status = iaid_pkg::ST_OK;
    res.word   = '0;
    case (op)
      iaid_pkg::OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          res.status = iaid_pkg::ST_FULL;
        end else if (pos > shadow_count) begin
          res.status = iaid_pkg::ST_RANGE;
        end else begin
          for (int i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = word;
          shadow_count++;
        end
      end
      iaid_pkg::OP_DELETE: begin
        if (pos >= shadow_count) begin
          res.status = iaid_pkg::ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      iaid_pkg::OP_READ: begin
        if (pos >= shadow_count) res.status = iaid_pkg::ST_RANGE;
        else res.word = shadow_words[pos];
      end
      // The spare operation code leaves everything as it is.
      default: begin
      end
    endcase
    res.count = CNT_W'(shadow_count);
    return res;
  endfunction

  // Checks responses first, then records the request taken at the same edge,
  // since a response can never belong to a request accepted at that edge.
  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      expected_results.delete();
      mismatch_count  <= 0;
      pending_results <= 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        got.status = status;
        got.word   = value_out;
        got.count  = fill_count;
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: response with none outstanding: status %0d word %0d count %0d",
                     $realtime, got.status, got.word, got.count);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.word !== want.word ||
              got.count !== want.count) begin
            if (mismatch_count < 10)
              $display("%0t: expected status %0d word %0d count %0d, got %0d %0d %0d",
                       $realtime, want.status, want.word, want.count,
                       got.status, got.word, got.count);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (req_valid && !req_stall)
        expected_results.push_back(apply_request(operation, position, value_in));
      pending_results <= expected_results.size();
    end
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

// Drives requests into the indexed array with random gaps and response stalls,
// and reports the verdict from the checker.
module testbench;

  localparam int unsigned DEPTH = 128;
  localparam logic [iaid_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  logic                                 clk = 1'b0;
  logic                                 rst = 1'b1;
  logic                                 req_valid = 1'b0;
  logic                                 req_stall;
  logic [iaid_pkg::OP_W-1:0]            operation = iaid_pkg::OP_READ;
  logic [iaid_pkg::POS_W-1:0]           position = '0;
  logic signed [iaid_pkg::WORD_W-1:0]   value_in = '0;
  logic                                 rsp_valid;
  logic                                 rsp_stall = 1'b0;
  logic [iaid_pkg::ST_W-1:0]            status;
  logic signed [iaid_pkg::WORD_W-1:0]   value_out;
  logic [$clog2(DEPTH+1)-1:0]           fill_count;

  int mismatch_count;
  int pending_results;

  // Rough fill level as seen by the sender, used to aim positions.
  int fill_est = 0;
  // While set, neither side inserts idle cycles.
  bit calm = 1'b0;
  int rsp_hold = 0;

  typedef logic [iaid_pkg::OP_W-1:0] OP_OP_W;

  indexed_array_insert_delete #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .position(position), .value_in(value_in),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .value_out(value_out), .fill_count(fill_count)
  );

  array_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .position(position), .value_in(value_in),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .status(status), .value_out(value_out), .fill_count(fill_count),
    .mismatch_count(mismatch_count), .pending_results(pending_results)
  );

  always #4 clk = ~clk;

  // The response side stalls for a random number of cycles after each response.
  always @(posedge clk) begin
    if (rst) begin
      rsp_hold = 0;
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_hold = calm ? 0 : $urandom_range(0, 8);
      else if (rsp_hold != 0) rsp_hold--;
      rsp_stall <= (rsp_hold != 0);
    end
  end

  // Sends one request after a random gap and waits until it is taken.
  task automatic issue(logic [iaid_pkg::OP_W-1:0] op, int unsigned pos,
                       logic [iaid_pkg::WORD_W-1:0] word);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    position  <= pos[iaid_pkg::POS_W-1:0];
    value_in  <= word;
    if (op == iaid_pkg::OP_INSERT && fill_est < DEPTH && pos <= fill_est) fill_est++;
    else if (op == iaid_pkg::OP_DELETE && pos < fill_est) fill_est--;
    @(posedge clk iff !req_stall);
  endtask

  // Holds the sender until every outstanding response has come back.
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Picks a request, mostly well formed, with a bias toward inserts given in percent.
  task automatic random_request(int ins_pct);
    int pick;
    logic [iaid_pkg::WORD_W-1:0] word;
    pick = $urandom_range(0, 99);
    word = ($urandom_range(0, 9) == 0)
           ? {$urandom_range(0, 1) == 1, {(iaid_pkg::WORD_W-1){1'b0}}}
           : $urandom;
    if (pick < 12) begin
      issue(OP_OP_W'($urandom_range(0, 3)), $urandom_range(0, DEPTH - 1), word);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < ins_pct)
        issue(iaid_pkg::OP_INSERT,
              $urandom_range(0, (fill_est < DEPTH) ? fill_est : DEPTH - 1), word);
      else if (pick < ins_pct + (100 - ins_pct) / 2)
        issue(iaid_pkg::OP_DELETE,
              (fill_est > 0) ? $urandom_range(0, fill_est - 1) : 0, word);
      else
        issue(iaid_pkg::OP_READ,
              (fill_est > 0) ? $urandom_range(0, fill_est - 1) : 0, word);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty array: every access is out of range, the spare code is ignored.
    issue(iaid_pkg::OP_READ, 0, 32'h0);
    issue(iaid_pkg::OP_DELETE, 0, 32'h0);
    issue(iaid_pkg::OP_INSERT, 1, 32'd100);
    issue(OP_SPARE, 127, 32'hFFFF_FFFF);
    // Inserts at the front, the end and the middle with extreme words.
    issue(iaid_pkg::OP_INSERT, 0, 32'h7FFF_FFFF);
    issue(iaid_pkg::OP_INSERT, 0, 32'h8000_0000);
    issue(iaid_pkg::OP_INSERT, 2, 32'hFFFF_FFFF);
    issue(iaid_pkg::OP_INSERT, 1, 32'd0);
    issue(iaid_pkg::OP_INSERT, 4, 32'd100);
    issue(iaid_pkg::OP_INSERT, 6, 32'd5);
    for (int i = 0; i < 6; i++) issue(iaid_pkg::OP_READ, i, 32'h0);
    issue(iaid_pkg::OP_READ, 127, 32'h0);
    issue(iaid_pkg::OP_DELETE, 5, 32'h0);
    issue(iaid_pkg::OP_DELETE, 0, 32'h0);
    issue(iaid_pkg::OP_DELETE, 127, 32'h0);
    issue(iaid_pkg::OP_INSERT, 127, 32'h1234_5678);
    issue(OP_SPARE, 0, 32'h0);
    issue(iaid_pkg::OP_READ, 1, 32'h0);

    // Fill to capacity, then try inserts on the full array around a read and a delete.
    while (fill_est < DEPTH) random_request(100);
    issue(iaid_pkg::OP_INSERT, 0, 32'h5555_5555);
    issue(iaid_pkg::OP_INSERT, 127, 32'hAAAA_AAAA);
    issue(iaid_pkg::OP_READ, 127, 32'h0);
    issue(iaid_pkg::OP_DELETE, 127, 32'h0);
    issue(iaid_pkg::OP_INSERT, 127, 32'hFFFF_FFFF);
    issue(iaid_pkg::OP_INSERT, 64, 32'h0);
    drain();

    // Random phases alternate between growing, shrinking and a balanced mix.
    for (int seg = 0; seg < 8; seg++) begin
      calm = (seg % 4 == 3);
      for (int n = 0; n < 125; n++)
        random_request((seg % 3 == 0) ? 85 : (seg % 3 == 1) ? 15 : 50);
      if (seg == 4) drain();
    end
    calm = 1'b0;

    drain();
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
